// ===== hw/rtl/aiq_pkg.sv =====
// ----------------------------------------------------------------------------
// aiq_pkg
// Shared types, widths and helpers for the absmax int8 quantizer.
// ----------------------------------------------------------------------------
package aiq_pkg;

	localparam int MAX_LEN = 64;
	localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);

	localparam int SMP_W   = 16;
	localparam int MAG_W   = 16;
	localparam int QV_W    = 8;
	localparam int QMAX    = 127;

	// quotient never exceeds 127, so eight quotient bits cover it
	localparam int QUO_W   = 8;
	localparam int DEN_W   = MAG_W + 1;
	localparam int NUM_W   = DEN_W + QUO_W - 1;
	localparam int STEP_W  = $clog2(QUO_W);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_START,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] numer;
		logic [DEN_W-1:0] denom;
	} div_req_t;

	function automatic logic [MAG_W-1:0] mag16(input logic [SMP_W-1:0] raw);
		logic [MAG_W-1:0] neg;
		neg = MAG_W'(~raw + SMP_W'(1));
		return raw[SMP_W-1] ? neg : MAG_W'(raw);
	endfunction

endpackage

// ===== hw/rtl/aiq_sample_mem.sv =====
// ----------------------------------------------------------------------------
// aiq_sample_mem
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aiq_sample_mem import aiq_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [SMP_W-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [SMP_W-1:0]  rd_data
);

	logic [SMP_W-1:0] mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/aiq_divider.sv =====
// ----------------------------------------------------------------------------
// aiq_divider
// Restoring divider, one quotient bit per cycle, QUO_W bit quotient.
// ----------------------------------------------------------------------------
module aiq_divider import aiq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [QUO_W-1:0] quot
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic              fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= STEP_W'(step_q + STEP_W'(1));
				if (step_q == STEP_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.numer;
			dsh_q <= {req.denom, (QUO_W-1)'(0)};
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= NUM_W'(rem_q - dsh_q);
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== hw/rtl/absmax_int8_quantize_core.sv =====
// ----------------------------------------------------------------------------
// absmax_int8_quantize_core
// Loading: one sample word per cycle. After the word marked last, and after
// each result is taken, the next result is made by a store read, divider
// start, 8 divide steps and done, then held until taken. The store is read
// only after all writes of a vector, so accesses never overlap. Reset clears
// count, scale and overflow; the store is not cleared.
// ----------------------------------------------------------------------------
module absmax_int8_quantize_core import aiq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [SMP_W-1:0] sample,
	input  logic             last_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [QV_W-1:0]  quantized_value,
	output logic [MAG_W-1:0] max_magnitude,
	output logic             last_out,
	output logic             overflow
);

	state_t            state_q, state_nx;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [MAG_W-1:0]  max_q;
	logic              drop_q;
	logic              sign_q;
	logic [QV_W-1:0]   qval_q;
	logic              last_q;
	logic              ovf_q;

	logic              in_acc;
	logic              out_acc;
	logic              room;
	logic [MAG_W-1:0]  in_mag;
	logic              mem_rd_en;
	logic [SMP_W-1:0]  sample_rd;
	logic [MAG_W-1:0]  rd_mag;
	logic              div_start;
	div_req_t          div_req;
	logic              div_done;
	logic [QUO_W-1:0]  div_quot;
	logic [QUO_W-1:0]  q_abs;
	logic [QV_W-1:0]   q_signed;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign room    = count_q < CNT_W'(MAX_LEN);
	assign in_mag  = mag16(sample);
	assign rd_mag  = mag16(sample_rd);

	aiq_sample_mem u_mem (
		.clk     (clk),
		.wr_en   (in_acc && room),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (sample),
		.rd_en   (mem_rd_en),
		.rd_addr (idx_q[ADDR_W-1:0]),
		.rd_data (sample_rd)
	);

	// numerator 2*127*|x| + m, denominator 2*m
	always_comb begin
		div_req.start = div_start;
		div_req.numer = NUM_W'((NUM_W'(rd_mag) << 8) - (NUM_W'(rd_mag) << 1)
			+ NUM_W'(max_q));
		div_req.denom = {max_q, 1'b0};
	end

	aiq_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign q_abs    = (div_quot > QUO_W'(QMAX)) ? QUO_W'(QMAX) : div_quot;
	assign q_signed = sign_q ? QV_W'(-q_abs) : QV_W'(q_abs);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && last_in) begin
					state_nx = ST_READ;
				end
			end
			ST_READ:  state_nx = ST_START;
			ST_START: state_nx = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_nx = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_stall) begin
					state_nx = last_q ? ST_LOAD : ST_READ;
				end
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		mem_rd_en = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_LOAD:  in_stall = 1'b0;
			ST_READ:  mem_rd_en = 1'b1;
			ST_START: div_start = 1'b1;
			ST_DIV:   ;
			ST_HOLD:  out_valid = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			idx_q   <= '0;
			max_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_acc) begin
				if (room) begin
					count_q <= CNT_W'(count_q + CNT_W'(1));
					if (in_mag > max_q) begin
						max_q <= in_mag;
					end
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (out_acc) begin
				if (last_q) begin
					count_q <= '0;
					idx_q   <= '0;
					max_q   <= '0;
					drop_q  <= 1'b0;
				end else begin
					idx_q <= CNT_W'(idx_q + CNT_W'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			sign_q <= sample_rd[SMP_W-1];
		end
		if (state_q == ST_DIV && div_done) begin
			qval_q <= (max_q == '0) ? '0 : q_signed;
			last_q <= CNT_W'(idx_q + CNT_W'(1)) == count_q;
			ovf_q  <= drop_q;
		end
	end

	assign quantized_value = qval_q;
	assign max_magnitude   = max_q;
	assign last_out        = last_q;
	assign overflow        = ovf_q;

`ifndef NO_ASSERTIONS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> (idx_q < count_q))
		else $error("emit index beyond stored count");

	a_qval_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (qval_q != 8'h80))
		else $error("quantized value outside -127..127");

	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && max_q == '0) |-> (qval_q == '0))
		else $error("nonzero result with zero scale");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_q) |=> (count_q == '0 && max_q == '0 && !drop_q))
		else $error("state not cleared after final word");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - absmax int8 quantizer testbench
// Streams sample vectors into the core and checks every quantized word
// against a behavioral predictor: scale tracking, round-half-away division,
// zero scale, the most negative sample and store overflow. Sender gaps and
// receiver stalls vary by phase.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [aiq_pkg::QV_W-1:0]  qv;
	logic [aiq_pkg::MAG_W-1:0] mag;
	logic                      last;
	logic                      ovf;
} quant_word_t;

class quant_scoreboard;
	logic [aiq_pkg::SMP_W-1:0] vec_store [aiq_pkg::MAX_LEN];
	int unsigned stored;
	int unsigned peak;
	bit dropped;
	quant_word_t pending_words[$];
	int unsigned mismatches;

	function new();
		stored = 0;
		peak = 0;
		dropped = 0;
		mismatches = 0;
	endfunction

	function int unsigned abs_sample(logic [aiq_pkg::SMP_W-1:0] raw);
		int v;
		v = $signed(raw);
		return (v < 0) ? -v : v;
	endfunction

	function logic [aiq_pkg::QV_W-1:0] to_int8(logic [aiq_pkg::SMP_W-1:0] raw,
			int unsigned scale);
		int unsigned q;
		if (scale == 0) begin
			return '0;
		end
		q = (2 * abs_sample(raw) * aiq_pkg::QMAX + scale) / (2 * scale);
		if (q > aiq_pkg::QMAX) begin
			q = aiq_pkg::QMAX;
		end
		return raw[aiq_pkg::SMP_W-1] ? aiq_pkg::QV_W'(-q) : aiq_pkg::QV_W'(q);
	endfunction

	function void note_input(logic [aiq_pkg::SMP_W-1:0] s, logic l);
		quant_word_t w;
		if (stored < aiq_pkg::MAX_LEN) begin
			vec_store[stored] = s;
			stored++;
			if (abs_sample(s) > peak) begin
				peak = abs_sample(s);
			end
		end else begin
			dropped = 1;
		end
		if (l) begin
			for (int k = 0; k < stored; k++) begin
				w.qv   = to_int8(vec_store[k], peak);
				w.mag  = aiq_pkg::MAG_W'(peak);
				w.last = (k + 1 == stored);
				w.ovf  = dropped;
				pending_words.push_back(w);
			end
			stored = 0;
			peak = 0;
			dropped = 0;
		end
	endfunction

	function void check_result(quant_word_t got);
		quant_word_t want;
		if (pending_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: unexpected word q=%0d mag=%0d last=%0b ovf=%0b",
					$time, $signed(got.qv), got.mag, got.last, got.ovf);
			end
			return;
		end
		want = pending_words.pop_front();
		if (got.qv !== want.qv || got.mag !== want.mag ||
				got.last !== want.last || got.ovf !== want.ovf) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch exp q=%0d mag=%0d last=%0b ovf=%0b",
					$time, $signed(want.qv), want.mag, want.last, want.ovf);
				$display("%0t:          got q=%0d mag=%0d last=%0b ovf=%0b",
					$time, $signed(got.qv), got.mag, got.last, got.ovf);
			end
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aiq_pkg::*;

	localparam int ITEMS       = 420;
	localparam int STALL_LIMIT = 4000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [SMP_W-1:0] sample;
	logic             last_in;
	logic             out_valid;
	logic             out_stall;
	logic [QV_W-1:0]  quantized_value;
	logic [MAG_W-1:0] max_magnitude;
	logic             last_out;
	logic             overflow;

	quant_scoreboard sb;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned items_sent;
	int unsigned quiet_cycles;

	absmax_int8_quantize_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quantized_value(quantized_value),
		.max_magnitude(max_magnitude),
		.last_out(last_out),
		.overflow(overflow)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_result('{quantized_value, max_magnitude, last_out, overflow});
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [SMP_W-1:0] s, input logic l);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		last_in  <= l;
		do @(posedge clk); while (in_stall);
		sb.note_input(s, l);
		items_sent++;
	endtask

	task automatic send_list(input logic [SMP_W-1:0] vals[$]);
		for (int i = 0; i < vals.size(); i++) begin
			send_word(vals[i], i == vals.size() - 1);
		end
	endtask

	function automatic logic [SMP_W-1:0] rand_sample(int mode);
		if (mode <= 4) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					3: return 16'hffff;
					default: return 16'h0001;
				endcase
			end
			return SMP_W'($urandom);
		end else if (mode <= 7) begin
			return SMP_W'(int'($urandom_range(0, 8)) - 4);
		end else if (mode == 8) begin
			return SMP_W'(int'($urandom_range(0, 600)) - 300);
		end
		return '0;
	endfunction

	task automatic send_random_vector();
		int len;
		int r;
		int mode;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			len = $urandom_range(1, 8);
		end else if (r < 85) begin
			len = $urandom_range(9, 32);
		end else if (r < 93) begin
			len = MAX_LEN;
		end else begin
			len = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
		end
		mode = $urandom_range(0, 9);
		for (int i = 0; i < len; i++) begin
			send_word(rand_sample(mode), i == len - 1);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		last_in = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes, zero scale, exact halves
		send_list('{16'h7fff});
		send_list('{16'h8000});
		send_list('{16'h0000});
		send_list('{16'd2, 16'd1, 16'hffff, 16'hfffe, 16'd0});
		send_list('{16'h8000, 16'h7fff, 16'd1, 16'hffff, 16'h4000});
		send_list('{16'd0, 16'd0, 16'd0});
		send_list('{16'd3, 16'hfffd, 16'd1});
		send_list('{16'h8001, 16'hffff});

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			while (items_sent < (phase + 1) * (ITEMS / 4)) begin
				send_random_vector();
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
